[src/cpsl_pkg.sv]
// ----------------------------------------------------------------------------
// cpsl_pkg: shared types and constants for the change-point sample log
// Command codes, memory port selects, controller command/status bundles and
// the reset values of the running statistics.
// ----------------------------------------------------------------------------
package cpsl_pkg;

    localparam int unsigned LOG_DEPTH_DEF = 256;

    // +16364.0 and -16364.0 in Q16.16
    localparam logic signed [31:0] MIN_RESET = 32'sh3FEC_0000;
    localparam logic signed [31:0] MAX_RESET = 32'shC014_0000;

    localparam int unsigned IN_W  = 72;
    localparam int unsigned OUT_W = 232;

    typedef enum logic [1:0] {
        CMD_LOG   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_SWEEP,
        WR_FIRST,
        WR_ENTRY,
        WR_CLEAR
    } wr_sel_t;

    typedef enum logic [1:0] {
        RD_PREV,
        RD_IDX,
        RD_FIRST,
        RD_LAST
    } rd_sel_t;

    typedef struct packed {
        logic    load_in;
        logic    stat_step;
        logic    clear_stats;
        wr_sel_t wr_sel;
        rd_sel_t rd_sel;
        logic    adv_wp;
        logic    acc_load;
        logic    div_start;
        logic    mean_set;
        logic    cap_entry;
        logic    cap_first;
        logic    set_span;
        logic    load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic time_newer;
        logic first_sample;
        logic count_zero;
        logic value_differs;
        logic sweep_last;
        logic div_done;
        logic out_free;
    } ctrl_stat_t;

endpackage

[src/cpsl_div.sv]
// ----------------------------------------------------------------------------
// cpsl_div: serial signed divider for the running mean
// Divides a signed 64-bit sum by an unsigned 32-bit count, one quotient bit
// per cycle, truncating toward zero. The quotient must fit in 32 bits.
// ----------------------------------------------------------------------------
module cpsl_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] dividend,
    input  logic        [31:0] divisor,
    output logic               done,
    output logic signed [31:0] quotient
);

    localparam int unsigned STEPS = 32;
    localparam int unsigned CNT_W = $clog2(STEPS);

    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [31:0]      rem_reg;
    logic [31:0]      rem_next;
    logic [31:0]      low_reg;
    logic [31:0]      low_next;
    logic [31:0]      q_reg;
    logic [31:0]      q_next;
    logic             neg_reg;
    logic             neg_next;

    logic [63:0]      mag;
    logic [32:0]      trial;
    logic             fits;

    assign mag   = dividend[63] ? (~dividend + 64'd1) : dividend;
    assign trial = {rem_reg, low_reg[31]};
    assign fits  = trial >= {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        q_next    = q_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            // the high half is already below the divisor
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = mag[63:32];
            low_next  = mag[31:0];
            q_next    = '0;
            neg_next  = dividend[63];
        end
        else if (busy_reg)
        begin
            rem_next = fits ? 32'(trial - {1'b0, divisor}) : trial[31:0];
            low_next = {low_reg[30:0], 1'b0};
            q_next   = {q_reg[30:0], fits};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        q_reg   <= q_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? $signed(~q_reg + 32'd1) : $signed(q_reg);

endmodule

[src/cpsl_datapath.sv]
// ----------------------------------------------------------------------------
// cpsl_datapath: registers, ring store and arithmetic of the sample log
// Holds the log state, the (count, value) ring memory, the statistics, the
// mean divider and the output register; acts only on controller commands.
// ----------------------------------------------------------------------------
module cpsl_datapath #(
    parameter int unsigned LOG_DEPTH = cpsl_pkg::LOG_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  cpsl_pkg::ctrl_cmd_t            cmd,
    output cpsl_pkg::ctrl_stat_t           stat,
    input  logic [cpsl_pkg::IN_W-1:0]      in_data,
    input  logic [1:0]                     in_user,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic [cpsl_pkg::OUT_W-1:0]     out_data
);

    localparam int unsigned ADDR_W    = $clog2(LOG_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(LOG_DEPTH - 1);

    // ring store
    logic        [31:0] count_mem [LOG_DEPTH];
    logic signed [31:0] value_mem [LOG_DEPTH];

    // latched input item
    cpsl_pkg::cmd_t     cmd_reg;
    logic        [31:0] time_reg;
    logic signed [31:0] value_reg;
    logic        [7:0]  idx_reg;

    // log state
    logic        [31:0] last_time_reg;
    logic        [31:0] counter_reg;
    logic        [31:0] wp_reg;
    logic [ADDR_W-1:0]  slot_reg;
    logic signed [31:0] min_reg;
    logic signed [31:0] max_reg;
    logic signed [31:0] mean_reg;
    logic [ADDR_W-1:0]  sweep_reg;

    // working registers
    logic signed [63:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic               accepted_reg;
    logic        [31:0] est_reg;
    logic signed [31:0] evl_reg;
    logic        [31:0] first_cnt_reg;
    logic        [31:0] span_reg;
    logic        [31:0] rd_cnt_reg;
    logic signed [31:0] rd_val_reg;
    logic               out_valid_reg;
    logic [cpsl_pkg::OUT_W-1:0] out_data_reg;

    logic [ADDR_W-1:0]  wr_addr;
    logic        [31:0] wr_cnt;
    logic signed [31:0] wr_val;
    logic               we_cnt;
    logic               we_val;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  next_slot;
    logic [ADDR_W-1:0]  prev_slot;
    logic [ADDR_W-1:0]  first_slot;
    logic               idx_in_range;
    logic signed [63:0] mean_ext;
    logic signed [63:0] cnt_ext;
    logic               div_done;
    logic signed [31:0] div_q;

    // slot of write position + 1, tracked without a modulo
    assign next_slot = (wp_reg == 32'hFFFF_FFFF) ? '0 :
                       ((slot_reg == LAST_SLOT) ? '0 : slot_reg + ADDR_W'(1));

    always_comb
    begin
        if (slot_reg != '0)
            prev_slot = slot_reg - ADDR_W'(1);
        else if (wp_reg >= 32'(LOG_DEPTH))
            prev_slot = LAST_SLOT;
        else
            prev_slot = '0;
    end

    assign first_slot   = (wp_reg > 32'(LOG_DEPTH)) ? next_slot : '0;
    assign idx_in_range = {24'd0, idx_reg} < 32'(LOG_DEPTH);
    assign mean_ext     = 64'(mean_reg);
    assign cnt_ext      = $signed({32'd0, counter_reg});

    always_comb
    begin
        wr_addr = slot_reg;
        wr_cnt  = counter_reg;
        wr_val  = value_reg;
        we_cnt  = 1'b0;
        we_val  = 1'b0;
        unique case (cmd.wr_sel)
            cpsl_pkg::WR_NONE:
            begin
                we_cnt = 1'b0;
            end
            cpsl_pkg::WR_SWEEP:
            begin
                wr_addr = sweep_reg;
                wr_cnt  = '0;
                wr_val  = '0;
                we_cnt  = 1'b1;
                we_val  = 1'b1;
            end
            cpsl_pkg::WR_FIRST:
            begin
                wr_cnt = 32'd1;
                we_cnt = 1'b1;
                we_val = 1'b1;
            end
            cpsl_pkg::WR_ENTRY:
            begin
                we_cnt = 1'b1;
                we_val = 1'b1;
            end
            cpsl_pkg::WR_CLEAR:
            begin
                // count of slot 0 only, the value stays
                wr_addr = '0;
                wr_cnt  = '0;
                we_cnt  = 1'b1;
            end
            default:
            begin
                we_cnt = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        unique case (cmd.rd_sel)
            cpsl_pkg::RD_PREV:  rd_addr = prev_slot;
            cpsl_pkg::RD_IDX:   rd_addr = ADDR_W'(idx_reg);
            cpsl_pkg::RD_FIRST: rd_addr = first_slot;
            cpsl_pkg::RD_LAST:  rd_addr = slot_reg;
            default:            rd_addr = slot_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we_cnt)
            count_mem[wr_addr] <= wr_cnt;
        if (we_val)
            value_mem[wr_addr] <= wr_val;
        rd_cnt_reg <= count_mem[rd_addr];
        rd_val_reg <= value_mem[rd_addr];
    end

    cpsl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (acc_reg),
        .divisor  (counter_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg <= '0;
            counter_reg   <= '0;
            wp_reg        <= '0;
            slot_reg      <= '0;
            min_reg       <= cpsl_pkg::MIN_RESET;
            max_reg       <= cpsl_pkg::MAX_RESET;
            mean_reg      <= '0;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wr_sel == cpsl_pkg::WR_SWEEP)
                sweep_reg <= sweep_reg + ADDR_W'(1);
            if (cmd.clear_stats)
            begin
                last_time_reg <= '0;
                counter_reg   <= '0;
                wp_reg        <= '0;
                slot_reg      <= '0;
                min_reg       <= cpsl_pkg::MIN_RESET;
                max_reg       <= cpsl_pkg::MAX_RESET;
                mean_reg      <= '0;
            end
            if (cmd.stat_step)
            begin
                last_time_reg <= time_reg;
                counter_reg   <= counter_reg + 32'd1;
                if (max_reg < value_reg)
                    max_reg <= value_reg;
                if (min_reg > value_reg)
                    min_reg <= value_reg;
            end
            if (cmd.adv_wp)
            begin
                wp_reg   <= wp_reg + 32'd1;
                slot_reg <= next_slot;
            end
            if (cmd.mean_set)
                mean_reg <= div_q;
            priority if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            cmd_reg      <= cpsl_pkg::cmd_t'(in_user);
            time_reg     <= in_data[31:0];
            value_reg    <= $signed(in_data[63:32]);
            idx_reg      <= in_data[71:64];
            accepted_reg <= 1'b0;
            est_reg      <= '0;
            evl_reg      <= '0;
        end
        if (cmd.stat_step)
        begin
            accepted_reg <= 1'b1;
            // old count is n-1
            prod_reg     <= mean_ext * cnt_ext;
        end
        if (cmd.acc_load)
            acc_reg <= prod_reg + 64'(value_reg);
        if (cmd.cap_entry && idx_in_range)
        begin
            est_reg <= rd_cnt_reg;
            evl_reg <= rd_val_reg;
        end
        if (cmd.cap_first)
            first_cnt_reg <= rd_cnt_reg;
        if (cmd.set_span)
            span_reg <= (wp_reg == '0) ? first_cnt_reg
                                       : rd_cnt_reg - first_cnt_reg + 32'd1;
        if (cmd.load_out)
            out_data_reg <= {7'd0, evl_reg, est_reg, span_reg, mean_reg,
                             max_reg, min_reg, counter_reg, accepted_reg};
    end

    assign stat.cmd           = cmd_reg;
    assign stat.time_newer    = time_reg > last_time_reg;
    assign stat.first_sample  = counter_reg == 32'd1;
    assign stat.count_zero    = counter_reg == '0;
    assign stat.value_differs = rd_val_reg != value_reg;
    assign stat.sweep_last    = sweep_reg == LAST_SLOT;
    assign stat.div_done      = div_done;
    assign stat.out_free      = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[src/cpsl_ctrl.sv]
// ----------------------------------------------------------------------------
// cpsl_ctrl: sequencing state machine of the sample log
// Runs the store sweep after reset, then walks each command through its
// memory accesses, the mean division and the span reads.
// ----------------------------------------------------------------------------
module cpsl_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  cpsl_pkg::ctrl_stat_t stat,
    output cpsl_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [4:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_DECODE,
        ST_STAT,
        ST_WR_FIRST,
        ST_WR_MAIN,
        ST_RD_PREV,
        ST_CMP,
        ST_WR_ADV,
        ST_MEAN,
        ST_DIV_GO,
        ST_DIV,
        ST_CLEAR,
        ST_READ,
        ST_READ_GET,
        ST_SPAN_A,
        ST_SPAN_B,
        ST_SPAN_C,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next      = state_reg;
        in_ready        = 1'b0;
        cmd.load_in     = 1'b0;
        cmd.stat_step   = 1'b0;
        cmd.clear_stats = 1'b0;
        cmd.wr_sel      = cpsl_pkg::WR_NONE;
        cmd.rd_sel      = cpsl_pkg::RD_LAST;
        cmd.adv_wp      = 1'b0;
        cmd.acc_load    = 1'b0;
        cmd.div_start   = 1'b0;
        cmd.mean_set    = 1'b0;
        cmd.cap_entry   = 1'b0;
        cmd.cap_first   = 1'b0;
        cmd.set_span    = 1'b0;
        cmd.load_out    = 1'b0;
        unique case (state_reg)
            ST_SWEEP:
            begin
                cmd.wr_sel = cpsl_pkg::WR_SWEEP;
                if (stat.sweep_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
                if (in_valid)
                    state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                unique case (stat.cmd)
                    cpsl_pkg::CMD_LOG:
                        state_next = stat.time_newer ? ST_STAT : ST_SPAN_A;
                    cpsl_pkg::CMD_CLEAR: state_next = ST_CLEAR;
                    cpsl_pkg::CMD_READ:  state_next = ST_READ;
                    cpsl_pkg::CMD_NOP:   state_next = ST_SPAN_A;
                    default:             state_next = ST_SPAN_A;
                endcase
            end
            ST_STAT:
            begin
                cmd.stat_step = 1'b1;
                state_next    = ST_WR_FIRST;
            end
            ST_WR_FIRST:
            begin
                // first sample since clear takes a slot of its own
                if (stat.first_sample)
                begin
                    cmd.wr_sel = cpsl_pkg::WR_FIRST;
                    cmd.adv_wp = 1'b1;
                end
                state_next = ST_WR_MAIN;
            end
            ST_WR_MAIN:
            begin
                cmd.wr_sel = cpsl_pkg::WR_ENTRY;
                state_next = ST_RD_PREV;
            end
            ST_RD_PREV:
            begin
                cmd.rd_sel = cpsl_pkg::RD_PREV;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (stat.value_differs)
                begin
                    cmd.adv_wp = 1'b1;
                    state_next = ST_WR_ADV;
                end
                else
                begin
                    state_next = ST_MEAN;
                end
            end
            ST_WR_ADV:
            begin
                cmd.wr_sel = cpsl_pkg::WR_ENTRY;
                state_next = ST_MEAN;
            end
            ST_MEAN:
            begin
                // hold the mean when the counter has wrapped to zero
                if (stat.count_zero)
                begin
                    state_next = ST_SPAN_A;
                end
                else
                begin
                    cmd.acc_load = 1'b1;
                    state_next   = ST_DIV_GO;
                end
            end
            ST_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.mean_set = 1'b1;
                    state_next   = ST_SPAN_A;
                end
            end
            ST_CLEAR:
            begin
                cmd.clear_stats = 1'b1;
                cmd.wr_sel      = cpsl_pkg::WR_CLEAR;
                state_next      = ST_SPAN_A;
            end
            ST_READ:
            begin
                cmd.rd_sel = cpsl_pkg::RD_IDX;
                state_next = ST_READ_GET;
            end
            ST_READ_GET:
            begin
                cmd.cap_entry = 1'b1;
                state_next    = ST_SPAN_A;
            end
            ST_SPAN_A:
            begin
                cmd.rd_sel = cpsl_pkg::RD_FIRST;
                state_next = ST_SPAN_B;
            end
            ST_SPAN_B:
            begin
                cmd.cap_first = 1'b1;
                cmd.rd_sel    = cpsl_pkg::RD_LAST;
                state_next    = ST_SPAN_C;
            end
            ST_SPAN_C:
            begin
                cmd.set_span = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_SWEEP;
        else
            state_reg <= state_next;
    end

endmodule

[src/change_point_sample_log_unit.sv]
// ----------------------------------------------------------------------------
// change_point_sample_log_unit: run-length ring log of timestamped samples
// Usage:
//   Input channel s_*: one command per transfer. s_tuser carries the command
//   (log sample, clear, read slot, no operation); s_tdata carries the sample
//   time, the Q16.16 sample value and the slot index.
//   Output channel m_*: one result transfer per command, with the accepted
//   flag, sample count, running min/max/mean, span and the read slot entry.
//   Sequence: a stored sample passes the ring writes, the compare with the
//   previous slot (a changed value opens a new run) and the one-bit-per-cycle
//   mean divider (32 steps); a stale sample, no-op, clear or slot read skips
//   the division. One command is in flight at a time and s_tready returns in
//   the cycle after the result is loaded.
//   Reset: the ring store is zeroed by a sweep over all LOG_DEPTH slots, one slot
//   per cycle; s_tready stays low until it completes.
//   Stall: a finished result waits in the output register while the next
//   command is taken and worked on; that command's result waits until the
//   register is free.
// ----------------------------------------------------------------------------
module change_point_sample_log_unit #(
    parameter int unsigned LOG_DEPTH = cpsl_pkg::LOG_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // sample_time[31:0], sample_value[63:32], slot_index[71:64]
    input  logic [cpsl_pkg::IN_W-1:0]  s_tdata,
    // cmd[1:0]
    input  logic [1:0]                 s_tuser,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // accepted[0], sample_count[32:1], min_value[64:33], max_value[96:65],
    // mean_value[128:97], span_count[160:129], entry_start[192:161],
    // entry_value[224:193], zero fill[231:225]
    output logic [cpsl_pkg::OUT_W-1:0] m_tdata
);

    cpsl_pkg::ctrl_cmd_t  ctrl_cmd;
    cpsl_pkg::ctrl_stat_t ctrl_stat;

    cpsl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (ctrl_stat),
        .cmd      (ctrl_cmd)
    );

    cpsl_datapath #(
        .LOG_DEPTH (LOG_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (ctrl_cmd),
        .stat      (ctrl_stat),
        .in_data   (s_tdata),
        .in_user   (s_tuser),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (m_tdata)
    );

    // one command in flight: input closes right after a transfer
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a command is in progress");

    // after a stored sample the running minimum is not above the running maximum
    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[0]) |-> ($signed(m_tdata[64:33]) <= $signed(m_tdata[96:65])))
        else $error("running minimum above running maximum");

    // truncated mean stays inside the extremes
    a_mean_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[0]) |->
        (($signed(m_tdata[128:97]) >= $signed(m_tdata[64:33])) &&
         ($signed(m_tdata[128:97]) <= $signed(m_tdata[96:65]))))
        else $error("running mean outside minimum and maximum");

endmodule

[bench/change_point_sample_log_unit_tb.sv]
// ----------------------------------------------------------------------------
// change_point_sample_log_unit_tb: self-checking bench for the sample log
// Drives log, clear, read and no-op commands over the input stream, predicts
// every result transfer with a cycle-free model of the ring log and its running
// statistics, and compares each output transfer field by field. Sender gaps
// and receiver stalls vary over several phases.
// ----------------------------------------------------------------------------
module change_point_sample_log_unit_tb;

    import cpsl_pkg::*;

    localparam int unsigned DEPTH = LOG_DEPTH_DEF;

    typedef struct packed {
        logic [6:0]         fill;
        logic signed [31:0] entry_value;
        logic [31:0]        entry_start;
        logic [31:0]        span_count;
        logic signed [31:0] mean_value;
        logic signed [31:0] max_value;
        logic signed [31:0] min_value;
        logic [31:0]        sample_count;
        logic               accepted;
    } log_result_t;

    class sample_log_scoreboard;
        log_result_t        pending_q[$];
        int unsigned        errors;
        int unsigned        n_stored;
        int unsigned        n_reads;
        int unsigned        n_clears;
        int unsigned        n_checked;
        bit                 ring_wrapped;

        bit [31:0]          last_stamp;
        bit [31:0]          n_samples;
        bit [31:0]          wr_pos;
        int                 stat_min;
        int                 stat_max;
        int                 stat_mean;
        bit [31:0]          slot_count[DEPTH];
        int                 slot_value[DEPTH];

        function new();
            errors = 0;
            n_stored = 0;
            n_reads = 0;
            n_clears = 0;
            n_checked = 0;
            ring_wrapped = 0;
            for (int i = 0; i < DEPTH; i++)
            begin
                slot_count[i] = '0;
                slot_value[i] = 0;
            end
            clear_log();
        endfunction

        function void clear_log();
            last_stamp = '0;
            n_samples = '0;
            wr_pos = '0;
            slot_count[0] = '0;
            stat_min = MIN_RESET;
            stat_max = MAX_RESET;
            stat_mean = 0;
        endfunction

        function void store_entry(bit [31:0] cnt, int v);
            slot_count[wr_pos % DEPTH] = cnt;
            slot_value[wr_pos % DEPTH] = v;
        endfunction

        function int unsigned prior_slot(bit [31:0] p);
            int unsigned r;
            r = p % DEPTH;
            if (r > 0)
                return r - 1;
            return (p >= DEPTH) ? DEPTH - 1 : 0;
        endfunction

        function bit [31:0] covered_span();
            int unsigned first;
            if (wr_pos == 0)
                return slot_count[0];
            first = (wr_pos > DEPTH) ? (wr_pos + 1) % DEPTH : 0;
            return slot_count[wr_pos % DEPTH] - slot_count[first] + 32'd1;
        endfunction

        // Work out the result of one accepted command and queue it.
        function void note_command(cmd_t cmd, bit [31:0] t, int v, bit [7:0] idx);
            log_result_t exp_r;
            longint      acc;
            exp_r = '0;
            case (cmd)
                CMD_LOG:
                begin
                    if (t > last_stamp)
                    begin
                        exp_r.accepted = 1'b1;
                        n_stored++;
                        last_stamp = t;
                        n_samples = n_samples + 32'd1;
                        if (stat_max < v) stat_max = v;
                        if (stat_min > v) stat_min = v;
                        if (n_samples != 0)
                        begin
                            acc = longint'(stat_mean) * longint'({32'b0, n_samples - 32'd1})
                                + longint'(v);
                            stat_mean = int'(acc / longint'({32'b0, n_samples}));
                        end
                        if (n_samples == 32'd1)
                        begin
                            store_entry(32'd1, v);
                            wr_pos = wr_pos + 32'd1;
                        end
                        store_entry(n_samples, v);
                        // open a new run when the value changes
                        if (v != slot_value[prior_slot(wr_pos)])
                        begin
                            wr_pos = wr_pos + 32'd1;
                            store_entry(n_samples, v);
                        end
                        if (wr_pos > DEPTH) ring_wrapped = 1;
                    end
                end
                CMD_CLEAR:
                begin
                    n_clears++;
                    clear_log();
                end
                CMD_READ:
                begin
                    n_reads++;
                    if (idx < DEPTH)
                    begin
                        exp_r.entry_start = slot_count[idx];
                        exp_r.entry_value = slot_value[idx];
                    end
                end
                default: ;
            endcase
            exp_r.sample_count = n_samples;
            exp_r.min_value = stat_min;
            exp_r.max_value = stat_max;
            exp_r.mean_value = stat_mean;
            exp_r.span_count = covered_span();
            pending_q.push_back(exp_r);
        endfunction

        function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v)
            begin
                errors++;
                $display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, act_v);
            end
        endfunction

        function void check_result(log_result_t act);
            log_result_t exp_r;
            if (pending_q.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result transfer: expected none actual %h", $time, act);
                return;
            end
            exp_r = pending_q.pop_front();
            n_checked++;
            compare_field("accepted", exp_r.accepted, act.accepted);
            compare_field("sample_count", exp_r.sample_count, act.sample_count);
            compare_field("min_value", exp_r.min_value, act.min_value);
            compare_field("max_value", exp_r.max_value, act.max_value);
            compare_field("mean_value", exp_r.mean_value, act.mean_value);
            compare_field("span_count", exp_r.span_count, act.span_count);
            compare_field("entry_start", exp_r.entry_start, act.entry_start);
            compare_field("entry_value", exp_r.entry_value, act.entry_value);
            compare_field("zero_fill", exp_r.fill, act.fill);
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;
    logic [1:0]        s_tuser = CMD_NOP;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;

    int unsigned       src_idle_pct = 0;
    int unsigned       snk_stall_pct = 0;
    int                prev_value = 0;

    sample_log_scoreboard sb = new();

    change_point_sample_log_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // Receiver: check on each output transfer, then pick the next ready level.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(log_result_t'(m_tdata));
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    task automatic push_command(cmd_t cmd, bit [31:0] t, bit [31:0] v, bit [7:0] idx);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {idx, v, t};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_command(cmd, t, int'(v), idx);
    endtask

    task automatic run_random(int unsigned n_items);
        int unsigned r;
        bit [32:0]   next_t;
        bit [31:0]   step;
        bit [31:0]   v;
        for (int unsigned i = 0; i < n_items; i++)
        begin
            r = $urandom_range(999);
            if (r < 2)
                push_command(CMD_CLEAR, $urandom, $urandom, 8'($urandom));
            else if (r < 150)
                push_command(CMD_READ, $urandom, $urandom, 8'($urandom));
            else if (r < 180)
                push_command(CMD_NOP, $urandom, $urandom, 8'($urandom));
            else if (r < 220)
                // stale time: not newer than the last stored one
                push_command(CMD_LOG, $urandom_range(sb.last_stamp), $urandom,
                             8'($urandom));
            else
            begin
                step = ($urandom_range(999) == 0) ? $urandom_range(32'h4000_0000, 1)
                                                   : $urandom_range(4096, 1);
                next_t = {1'b0, sb.last_stamp} + step;
                case ($urandom_range(9))
                    0, 1, 2, 3, 4: v = $urandom;
                    5: v = 32'h0000_0000;
                    6: v = 32'h0001_0000;
                    7: v = 32'hFFFF_0000;
                    default: v = prev_value;
                endcase
                // restart the timeline once it would run past the top
                if (next_t[32])
                    push_command(CMD_CLEAR, $urandom, $urandom, 8'($urandom));
                else
                begin
                    push_command(CMD_LOG, next_t[31:0], v, 8'($urandom));
                    prev_value = v;
                end
            end
        end
    endtask

    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed part, no idling
        push_command(CMD_READ, 32'h0, 32'h0, 8'd0);
        push_command(CMD_LOG, 32'h0, 32'h1234_5678, 8'hFF);
        push_command(CMD_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        push_command(CMD_LOG, 32'd1, 32'h7FFF_FFFF, 8'd0);
        push_command(CMD_LOG, 32'd2, 32'h7FFF_FFFF, 8'd0);
        push_command(CMD_LOG, 32'd2, 32'd5, 8'd0);
        push_command(CMD_LOG, 32'd3, 32'h8000_0000, 8'd0);
        push_command(CMD_LOG, 32'd4, 32'hFFFF_FFFF, 8'd0);
        push_command(CMD_LOG, 32'd5, 32'hFFFF_FFFF, 8'd0);
        push_command(CMD_READ, 32'h0, 32'h0, 8'd0);
        push_command(CMD_READ, 32'h0, 32'h0, 8'd1);
        push_command(CMD_READ, 32'h0, 32'h0, 8'd2);
        push_command(CMD_READ, 32'h0, 32'h0, 8'd3);
        push_command(CMD_LOG, 32'hFFFF_FFFF, 32'h0001_0000, 8'd0);
        push_command(CMD_LOG, 32'd6, 32'h0002_0000, 8'd0);
        push_command(CMD_READ, 32'h0, 32'h0, 8'd255);
        push_command(CMD_CLEAR, 32'h0, 32'h0, 8'd0);
        push_command(CMD_READ, 32'h0, 32'h0, 8'd0);
        push_command(CMD_LOG, 32'd1, MIN_RESET, 8'd0);
        push_command(CMD_LOG, 32'd100, MAX_RESET, 8'd0);
        push_command(CMD_NOP, $urandom, $urandom, 8'hAA);
        push_command(CMD_READ, 32'h0, 32'h0, 8'hAA);
        push_command(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);

        src_idle_pct = 0;  snk_stall_pct = 0;
        run_random(225);
        src_idle_pct = 78; snk_stall_pct = 0;
        run_random(225);
        src_idle_pct = 0;  snk_stall_pct = 78;
        run_random(225);
        src_idle_pct = 18; snk_stall_pct = 18;
        run_random(225);
        s_tvalid <= 1'b0;

        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        $display("Checked %0d results: %0d samples stored, %0d slot reads, %0d clears",
                 sb.n_checked, sb.n_stored, sb.n_reads, sb.n_clears);
        $display("Write position passed the ring depth: %0d", sb.ring_wrapped);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[files.f]
src/cpsl_pkg.sv
src/cpsl_div.sv
src/cpsl_datapath.sv
src/cpsl_ctrl.sv
src/change_point_sample_log_unit.sv
bench/change_point_sample_log_unit_tb.sv
